FILE: rtl/qmru_pkg.sv
// Package for the quaternion multiply / rotate unit.
// Fixed-point format, derived widths, function codes, product slot tables and clip helper.
// No dependencies.
package qmru_pkg;

    localparam int FRAC_BITS = 30;
    // width of a truncated 32x32 product
    localparam int P_W = 64 - FRAC_BITS;
    // width of sums of up to four products plus one
    localparam int S_W = P_W + 3;

    localparam logic signed [S_W-1:0] ONE_S   = S_W'(1) <<< FRAC_BITS;
    localparam logic signed [S_W-1:0] SAT_MAX = (S_W'(1) <<< 31) - S_W'(1);
    localparam logic signed [S_W-1:0] SAT_MIN = -(S_W'(1) <<< 31);

    typedef enum logic [1:0] {
        FN_MUL  = 2'd0,
        FN_B2F  = 2'd1,
        FN_F2B  = 2'd2,
        FN_NORM = 2'd3
    } t_func;

    // component index: 0 w, 1 x, 2 y, 3 z
    // rotate slots: ww xx yy zz xy zw xz yw yz xw
    localparam int N_ROT = 10;
    localparam logic [1:0] ROT_L [N_ROT] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                             2'd3, 2'd1, 2'd2, 2'd2, 2'd1};
    localparam logic [1:0] ROT_R [N_ROT] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2,
                                             2'd0, 2'd3, 2'd0, 2'd3, 2'd0};

    typedef struct packed {
        logic signed [31:0] v;
        logic               s;
    } t_sat;

    function automatic t_sat sat32(input logic signed [S_W-1:0] v);
        t_sat res;
        if (v > SAT_MAX) begin
            res.v = 32'sh7FFF_FFFF;
            res.s = 1'b1;
        end else if (v < SAT_MIN) begin
            res.v = 32'sh8000_0000;
            res.s = 1'b1;
        end else begin
            res.v = v[31:0];
            res.s = 1'b0;
        end
        return res;
    endfunction

endpackage

FILE: rtl/qmru_fmul.sv
// One registered fixed-point multiplier lane: 32x32 signed product, floor shift by FRAC_BITS.
// Depends on qmru_pkg.
module qmru_fmul (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [31:0]               i_a,
    input  logic signed [31:0]               i_b,
    output logic signed [qmru_pkg::P_W-1:0]  o_p
);

    logic signed [63:0]              w_prod;
    logic signed [63:0]              w_shr;
    logic signed [qmru_pkg::P_W-1:0] r_p;

    assign w_prod = i_a * i_b;
    assign w_shr  = w_prod >>> qmru_pkg::FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_shr[qmru_pkg::P_W-1:0];
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/quaternion_multiply_rotate_unit_top.sv
// Quaternion multiply / rotate / quick-normalize unit, four-stage pipeline.
// Throughput 1 item per cycle while m_axis_tready does not stall the output.
// Stages: product array, coefficient / factor sums, second product array, final sums and clip.
// Each stage holds while its successor is full and stalled; bubbles are filled.
// Reset (synchronous, active low) clears only the stage valid bits.
// Depends on qmru_pkg and qmru_fmul.
module quaternion_multiply_rotate_unit_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [1:0]   s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // r_w, r_x, r_y, r_z
    output logic         m_axis_tuser    // saturated
);

    localparam int PW = qmru_pkg::P_W;
    localparam int SW = qmru_pkg::S_W;

    // stage valid bits and load enables
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    assign w_en4 = !r_v4 || m_axis_tready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: first product array ----------------
    logic signed [31:0] w_a [4];
    logic signed [31:0] w_b [4];
    logic signed [31:0] w_l1 [16];
    logic signed [31:0] w_r1 [16];
    logic signed [PW-1:0] w_p1 [16];
    qmru_pkg::t_func w_func_in;

    assign w_func_in = qmru_pkg::t_func'(s_axis_tuser);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_a[i] = s_axis_tdata[32*i +: 32];
            w_b[i] = s_axis_tdata[128 + 32*i +: 32];
        end
        for (int k = 0; k < 16; k++) begin
            if (w_func_in == qmru_pkg::FN_MUL) begin
                w_l1[k] = w_a[2'(k / 4)];
                w_r1[k] = w_b[2'(k % 4)];
            end else if (k < qmru_pkg::N_ROT) begin
                w_l1[k] = w_a[qmru_pkg::ROT_L[k]];
                w_r1[k] = w_a[qmru_pkg::ROT_R[k]];
            end else begin
                w_l1[k] = '0;
                w_r1[k] = '0;
            end
        end
    end

    for (genvar g = 0; g < 16; g++) begin : g_mul1
        qmru_fmul u_fmul (
            .i_clk (i_clk),
            .i_en  (w_en1),
            .i_a   (w_l1[g]),
            .i_b   (w_r1[g]),
            .o_p   (w_p1[g])
        );
    end

    qmru_pkg::t_func    r_func1;
    logic signed [31:0] r_a1 [4];
    logic signed [31:0] r_vec1 [3];

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_func1 <= w_func_in;
            for (int i = 0; i < 4; i++) r_a1[i] <= w_a[i];
            for (int i = 0; i < 3; i++) r_vec1[i] <= w_b[i+1];
        end
    end

    // ---------------- stage 2: sums, coefficients, normalize factor ----------------
    logic signed [SW-1:0] w_e [16];
    logic signed [SW-1:0] w_h2 [4];
    logic signed [SW-1:0] w_m2 [9];
    logic signed [SW-1:0] w_eps, w_fw;
    qmru_pkg::t_sat       w_msat [9];
    qmru_pkg::t_sat       w_fsat;
    logic                 w_sat2;

    always_comb begin
        logic any_m;
        any_m = 1'b0;
        for (int k = 0; k < 16; k++) w_e[k] = SW'(w_p1[k]);
        w_h2[0] = w_e[0] - w_e[5]  - w_e[10] - w_e[15];
        w_h2[1] = w_e[1] + w_e[4]  + w_e[11] - w_e[14];
        w_h2[2] = w_e[2] - w_e[7]  + w_e[8]  + w_e[13];
        w_h2[3] = w_e[3] + w_e[6]  - w_e[9]  + w_e[12];
        // slots: 0 ww 1 xx 2 yy 3 zz 4 xy 5 zw 6 xz 7 yw 8 yz 9 xw
        w_m2[0] = w_e[1] + w_e[0] - w_e[2] - w_e[3];
        w_m2[1] = (w_e[4] - w_e[5]) <<< 1;
        w_m2[2] = (w_e[6] + w_e[7]) <<< 1;
        w_m2[3] = (w_e[4] + w_e[5]) <<< 1;
        w_m2[4] = w_e[2] + w_e[0] - w_e[1] - w_e[3];
        w_m2[5] = (w_e[8] - w_e[9]) <<< 1;
        w_m2[6] = (w_e[6] - w_e[7]) <<< 1;
        w_m2[7] = (w_e[8] + w_e[9]) <<< 1;
        w_m2[8] = w_e[3] + w_e[0] - w_e[1] - w_e[2];
        for (int k = 0; k < 9; k++) begin
            w_msat[k] = qmru_pkg::sat32(w_m2[k]);
            any_m     = any_m | w_msat[k].s;
        end
        w_eps  = qmru_pkg::ONE_S - (w_e[0] + w_e[1] + w_e[2] + w_e[3]);
        w_fw   = qmru_pkg::ONE_S + (w_eps >>> 1);
        w_fsat = qmru_pkg::sat32(w_fw);
        case (r_func1)
            qmru_pkg::FN_MUL:  w_sat2 = 1'b0;
            qmru_pkg::FN_NORM: w_sat2 = w_fsat.s;
            default:           w_sat2 = any_m;
        endcase
    end

    qmru_pkg::t_func      r_func2;
    logic signed [SW-1:0] r_h2 [4];
    logic signed [31:0]   r_m2 [9];
    logic signed [31:0]   r_f2;
    logic signed [31:0]   r_a2 [4];
    logic signed [31:0]   r_vec2 [3];
    logic                 r_sat2;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_func2 <= r_func1;
            r_f2    <= w_fsat.v;
            r_sat2  <= w_sat2;
            for (int i = 0; i < 4; i++) begin
                r_h2[i] <= w_h2[i];
                r_a2[i] <= r_a1[i];
            end
            for (int i = 0; i < 9; i++) r_m2[i] <= w_msat[i].v;
            for (int i = 0; i < 3; i++) r_vec2[i] <= r_vec1[i];
        end
    end

    // ---------------- stage 3: second product array ----------------
    logic signed [31:0]   w_l3 [9];
    logic signed [31:0]   w_r3 [9];
    logic signed [PW-1:0] w_q3 [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (r_func2 == qmru_pkg::FN_NORM && k < 4) begin
                w_l3[k] = r_a2[k];
                w_r3[k] = r_f2;
            end else if (r_func2 == qmru_pkg::FN_B2F) begin
                w_l3[k] = r_m2[k];
                w_r3[k] = r_vec2[k % 3];
            end else begin
                w_l3[k] = r_m2[(k % 3) * 3 + k / 3];
                w_r3[k] = r_vec2[k % 3];
            end
        end
    end

    for (genvar g = 0; g < 9; g++) begin : g_mul3
        qmru_fmul u_fmul (
            .i_clk (i_clk),
            .i_en  (w_en3),
            .i_a   (w_l3[g]),
            .i_b   (w_r3[g]),
            .o_p   (w_q3[g])
        );
    end

    qmru_pkg::t_func      r_func3;
    logic signed [SW-1:0] r_h3 [4];
    logic                 r_sat3;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_func3 <= r_func2;
            r_sat3  <= r_sat2;
            for (int i = 0; i < 4; i++) r_h3[i] <= r_h2[i];
        end
    end

    // ---------------- stage 4: final sums and clip ----------------
    logic signed [SW-1:0] w_res [4];
    qmru_pkg::t_sat       w_rsat [4];
    logic [127:0]         w_data4;
    logic                 w_sat4;

    always_comb begin
        w_sat4 = r_sat3;
        case (r_func3)
            qmru_pkg::FN_MUL: begin
                for (int i = 0; i < 4; i++) w_res[i] = r_h3[i];
            end
            qmru_pkg::FN_NORM: begin
                for (int i = 0; i < 4; i++) w_res[i] = SW'(w_q3[i]);
            end
            default: begin
                w_res[0] = '0;
                for (int r = 0; r < 3; r++) begin
                    w_res[r+1] = SW'(w_q3[3*r]) + SW'(w_q3[3*r+1]) + SW'(w_q3[3*r+2]);
                end
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            w_rsat[i]          = qmru_pkg::sat32(w_res[i]);
            w_data4[32*i +: 32] = w_rsat[i].v;
            w_sat4             = w_sat4 | w_rsat[i].s;
        end
    end

    logic [127:0] r_data4;
    logic         r_sat4;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_data4 <= w_data4;
            r_sat4  <= w_sat4;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = r_data4;
    assign m_axis_tuser  = r_sat4;

endmodule
